>>> src/usp_pkg.sv
package usp_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VEC_W        = MAX_VERTICES;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 6;
  localparam int DIST_W       = 5;
  localparam int ACT_W        = 2;

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  typedef logic [VEC_W-1:0]  vec_t;
  typedef logic [VIDX_W-1:0] vidx_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic vidx_t lowest_set(input vec_t v);
    vidx_t r;
    r = '0;
    for (int i = VEC_W - 1; i >= 0; i--) begin
      if (v[i]) r = vidx_t'(i);
    end
    return r;
  endfunction

  function automatic vec_t one_hot(input vidx_t idx);
    return vec_t'(1) << idx;
  endfunction

endpackage

>>> src/unit_graph_shortest_path_and_parity_unit.sv
// Add edge: accept, write first row, write second row, in that order. Clear: row valid bits reset.
// Query: search visits one frontier vertex at a time, level by level (empty for a source
//   out of range), bound by the single adjacency read port; then one result per cycle
//   while the output is not stalled, one per active vertex (clamped vertex_count) in total.
// One item is processed at a time; the output register lets the last result wait.
// Reset: no edges (row valid bits cleared at once), vertex_count = 32, no sweep.
module unit_graph_shortest_path_and_parity_unit import usp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [CNT_W-1:0]  first_vertex_i,
  input  logic [CNT_W-1:0]  second_vertex_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CNT_W-1:0]  vertex_o,
  output logic [DIST_W-1:0] hop_distance_o,
  output logic              reachable_o,
  output logic              odd_degree_o,
  output logic              last_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD_A  = 3'd1;
  localparam logic [2:0] ST_ADD_B  = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cfg_q;
  vec_t              row_valid_q, row_valid_d;   // cleared rows read as zero
  logic              rd_valid_q;                 // valid tag of the row in flight
  vec_t              visited_q, visited_d;
  vec_t              frontier_q, frontier_d;
  vec_t              acc_q, acc_d;               // union of rows of current level
  logic [DIST_W-1:0] level_q, level_d;
  vidx_t             va_q, va_d, vb_q, vb_d;
  logic              pend_q, pend_d;             // a read result is waiting
  logic [CNT_W-1:0]  idx_q, idx_d;               // next vertex to read in emit
  vidx_t             pidx_q, pidx_d;             // vertex of the pending read

  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  vertex_q;
  logic [DIST_W-1:0] hop_q;
  logic              reach_q, odd_q, last_q;

  // memory ports
  logic              adj_re, adj_we;
  vidx_t             adj_raddr, adj_waddr;
  vec_t              adj_wdata, adj_rdata;
  logic              dist_re, dist_we;
  vidx_t             dist_raddr, dist_waddr;
  logic [DIST_W-1:0] dist_wdata, dist_rdata;

  logic [CNT_W-1:0]  n_eff;
  vec_t              mask;
  vec_t              row_eff;
  vec_t              next_front;
  logic              in_xfer, add_ok, src_ok, out_free, load, issue;
  vidx_t             a_idx, b_idx, srch_v;

  // Active vertex count: zero acts as one, large values clamp.
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_q > CNT_W'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = cfg_q;
    end
    for (int i = 0; i < VEC_W; i++) begin
      mask[i] = (CNT_W'(i) < n_eff);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign a_idx      = vidx_t'(first_vertex_i - CNT_W'(1));
  assign b_idx      = vidx_t'(second_vertex_i - CNT_W'(1));
  assign add_ok     = (first_vertex_i != '0) && (first_vertex_i <= CNT_W'(MAX_VERTICES)) &&
                      (second_vertex_i != '0) && (second_vertex_i <= CNT_W'(MAX_VERTICES));
  assign src_ok     = (first_vertex_i != '0) && (first_vertex_i <= n_eff);

  assign row_eff    = rd_valid_q ? adj_rdata : '0;
  assign next_front = acc_q & mask & ~visited_q;
  assign srch_v     = lowest_set(frontier_q);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = (state_q == ST_EMIT) && pend_q && out_free;
  assign issue      = (state_q == ST_EMIT) && (idx_q < n_eff) && (!pend_q || load);

  always_comb begin
    state_d     = state_q;
    row_valid_d = row_valid_q;
    visited_d   = visited_q;
    frontier_d  = frontier_q;
    acc_d       = acc_q;
    level_d     = level_q;
    va_d        = va_q;
    vb_d        = vb_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    adj_re      = 1'b0;
    adj_raddr   = '0;
    adj_we      = 1'b0;
    adj_waddr   = '0;
    adj_wdata   = '0;
    dist_re     = 1'b0;
    dist_raddr  = '0;
    dist_we     = 1'b0;
    dist_waddr  = '0;
    dist_wdata  = level_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (action_i)
            ACT_ADD: begin
              if (add_ok) begin
                adj_re    = 1'b1;
                adj_raddr = a_idx;
                va_d      = a_idx;
                vb_d      = b_idx;
                state_d   = ST_ADD_A;
              end
            end
            ACT_CLEAR: begin
              row_valid_d = '0;
            end
            ACT_QUERY: begin
              frontier_d = src_ok ? one_hot(a_idx) : '0;
              visited_d  = src_ok ? one_hot(a_idx) : '0;
              acc_d      = '0;
              level_d    = '0;
              pend_d     = 1'b0;
              state_d    = ST_SEARCH;
            end
            default: ;
          endcase
        end
      end

      // Read-modify-write of the first row; read of the second row
      // overlaps the write (same row: the old data gives the same result).
      ST_ADD_A: begin
        adj_we             = 1'b1;
        adj_waddr          = va_q;
        adj_wdata          = row_eff | one_hot(vb_q);
        row_valid_d[va_q]  = 1'b1;
        adj_re             = 1'b1;
        adj_raddr          = vb_q;
        state_d            = ST_ADD_B;
      end

      ST_ADD_B: begin
        adj_we             = 1'b1;
        adj_waddr          = vb_q;
        adj_wdata          = row_eff | one_hot(va_q);
        row_valid_d[vb_q]  = 1'b1;
        state_d            = ST_IDLE;
      end

      // One frontier vertex per cycle: record its distance, fetch its row.
      ST_SEARCH: begin
        if (pend_q) acc_d = acc_q | row_eff;
        if (frontier_q != '0) begin
          adj_re             = 1'b1;
          adj_raddr          = srch_v;
          dist_we            = 1'b1;
          dist_waddr         = srch_v;
          frontier_d[srch_v] = 1'b0;
          pend_d             = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            // level finished
            if (next_front == '0) begin
              idx_d   = '0;
              state_d = ST_EMIT;
            end else begin
              frontier_d = next_front;
              visited_d  = visited_q | next_front;
              acc_d      = '0;
              level_d    = (level_q == '1) ? level_q : DIST_W'(level_q + 1'b1);
            end
          end
        end
      end

      ST_EMIT: begin
        if (issue) begin
          adj_re     = 1'b1;
          adj_raddr  = vidx_t'(idx_q);
          dist_re    = 1'b1;
          dist_raddr = vidx_t'(idx_q);
          pidx_d     = vidx_t'(idx_q);
          idx_d      = CNT_W'(idx_q + 1'b1);
          pend_d     = 1'b1;
        end else if (load) begin
          pend_d = 1'b0;
          if (idx_q == n_eff) state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CNT_W'(MAX_VERTICES);
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      visited_q   <= '0;
      frontier_q  <= '0;
      acc_q       <= '0;
      level_q     <= '0;
      va_q        <= '0;
      vb_q        <= '0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      row_valid_q <= row_valid_d;
      if (adj_re) rd_valid_q <= row_valid_q[adj_raddr];
      visited_q   <= visited_d;
      frontier_q  <= frontier_d;
      acc_q       <= acc_d;
      level_q     <= level_d;
      va_q        <= va_d;
      vb_q        <= vb_d;
      pend_q      <= pend_d;
      idx_q       <= idx_d;
      pidx_q      <= pidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; loaded from the pending read.
  always_ff @(posedge clk_i) begin
    if (load) begin
      vertex_q <= CNT_W'(pidx_q) + CNT_W'(1);
      reach_q  <= visited_q[pidx_q];
      hop_q    <= visited_q[pidx_q] ? dist_rdata : '0;
      odd_q    <= ^(row_eff & mask);
      last_q   <= (CNT_W'(pidx_q) + CNT_W'(1)) == n_eff;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_o       = vertex_q;
  assign hop_distance_o = hop_q;
  assign reachable_o    = reach_q;
  assign odd_degree_o   = odd_q;
  assign last_o         = last_q;

  usp_ram #(
    .WIDTH(VEC_W),
    .DEPTH(MAX_VERTICES)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(adj_wdata),
    .re_i   (adj_re),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  usp_ram #(
    .WIDTH(DIST_W),
    .DEPTH(MAX_VERTICES)
  ) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .re_i   (dist_re),
    .raddr_i(dist_raddr),
    .rdata_o(dist_rdata)
  );

  // Every frontier vertex has already been marked visited.
  a_frontier_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> ((frontier_q & ~visited_q) == '0))
    else $error("frontier vertex not marked visited");

  // A waiting read result is never overwritten while the output is stalled.
  a_emit_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && pend_q && !out_free |-> !adj_re && !dist_re)
    else $error("read issued over a pending result");

  // Leaving the emit phase always leaves the last-flagged result in the register.
  a_emit_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && (state_d == ST_IDLE) |=> out_valid_q && last_q)
    else $error("query ended without its last result");

endmodule

>>> src/usp_ram.sv
module usp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sim/unit_graph_shortest_path_and_parity_unit_test.sv
module unit_graph_shortest_path_and_parity_unit_test import usp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Action code 3 has no meaning; the block must swallow it silently.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int MISMATCH_SHOWN = 10;
  localparam int TARGET_OPS     = 170;
  localparam int SQUEEZE_CYCLES = 300;

  // One input transfer: an edge add, a clear or a query.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CNT_W-1:0] first_v;
    logic [CNT_W-1:0] second_v;
  } graph_op_t;

  // One output transfer: the search result for a single vertex.
  typedef struct packed {
    logic [CNT_W-1:0]  vertex;
    logic [DIST_W-1:0] hops;
    logic              reach;
    logic              odd;
    logic              last;
  } vertex_report_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i     = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [ACT_W-1:0]  action_i        = '0;
  logic [CNT_W-1:0]  first_vertex_i  = '0;
  logic [CNT_W-1:0]  second_vertex_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [CNT_W-1:0]  vertex_o;
  logic [DIST_W-1:0] hop_distance_o;
  logic              reachable_o;
  logic              odd_degree_o;
  logic              last_o;

  unit_graph_shortest_path_and_parity_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .first_vertex_i (first_vertex_i),
    .second_vertex_i(second_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_o       (vertex_o),
    .hop_distance_o (hop_distance_o),
    .reachable_o    (reachable_o),
    .odd_degree_o   (odd_degree_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ops waiting to be offered, and vertex reports the block still owes us.
  graph_op_t      pending_ops [$];
  vertex_report_t reports_due [$];

  // Shadow of the block: adjacency rows (column j is bit j-1) and the count reg.
  vec_t             edge_rows [MAX_VERTICES];
  logic [CNT_W-1:0] vertex_limit = 6'd32;

  int counted_ops  = 0;  // ops that do real work (ignored ones not counted)
  int accepted_ops = 0;
  int error_count  = 0;
  int send_pause   = 0;
  int recv_pause   = 0;
  bit calm         = 1'b0;  // phase with no idling on either side
  bit squeeze_req  = 1'b0;
  logic hold_off   = 1'b0;

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MISMATCH_SHOWN) $display("%s", msg);
  endfunction

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Mostly vertices in use, some stored-but-inactive ones, a few out of range.
  function automatic int pick_vertex(input int n);
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, n);
    if (r < 19) return $urandom_range(1, MAX_VERTICES);
    return $urandom_range(0, 63);
  endfunction

  function automatic void queue_op(input logic [ACT_W-1:0] act, input int a, input int b);
    graph_op_t op;
    op.action   = act;
    op.first_v  = CNT_W'(a);
    op.second_v = CNT_W'(b);
    pending_ops.push_back(op);
    if (act == ACT_QUERY || act == ACT_CLEAR ||
        (act == ACT_ADD && a >= 1 && a <= MAX_VERTICES && b >= 1 && b <= MAX_VERTICES))
      counted_ops++;
  endfunction

  // Path through n randomly ordered active vertices (m of them), then a query
  // from one end so the search runs m-1 levels deep.
  function automatic void queue_chain(input int n, input int m);
    int order [MAX_VERTICES];
    int j;
    int t;
    for (int i = 0; i < MAX_VERTICES; i++) order[i] = i + 1;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    queue_op(ACT_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
    for (int i = 1; i < m; i++) queue_op(ACT_ADD, order[i-1], order[i]);
    queue_op(ACT_QUERY, order[0], $urandom_range(0, 63));
  endfunction

  // Update the shadow graph for one accepted op; a query runs a level-by-level
  // BFS over the active vertices and queues one report per vertex.
  function automatic void apply_op(input graph_op_t op);
    int n;
    int depth;
    vec_t in_use;
    vec_t seen;
    vec_t frontier;
    vec_t grown;
    logic [DIST_W-1:0] hops [MAX_VERTICES];
    vertex_report_t rep;
    case (op.action)
      ACT_ADD: begin
        if (op.first_v >= 1 && op.first_v <= MAX_VERTICES &&
            op.second_v >= 1 && op.second_v <= MAX_VERTICES) begin
          edge_rows[op.first_v - 1][op.second_v - 1] = 1'b1;
          edge_rows[op.second_v - 1][op.first_v - 1] = 1'b1;
        end
      end
      ACT_CLEAR: begin
        foreach (edge_rows[i]) edge_rows[i] = '0;
      end
      ACT_QUERY: begin
        // count 0 behaves as 1, anything past the array as the full array
        if (vertex_limit == 0) n = 1;
        else if (vertex_limit > MAX_VERTICES) n = MAX_VERTICES;
        else n = int'(vertex_limit);
        in_use   = (n >= VEC_W) ? '1 : (vec_t'(1) << n) - vec_t'(1);
        seen     = '0;
        frontier = '0;
        foreach (hops[i]) hops[i] = '0;
        // a source outside 1..n reaches nothing at all, not even itself
        if (op.first_v >= 1 && op.first_v <= n) begin
          frontier = vec_t'(1) << (op.first_v - 1);
          seen     = frontier;
        end
        depth = 0;
        while (frontier != '0) begin
          grown = '0;
          for (int v = 0; v < n; v++) if (frontier[v]) grown |= edge_rows[v];
          grown &= in_use & ~seen;
          depth++;
          for (int v = 0; v < n; v++)
            if (grown[v]) hops[v] = DIST_W'((depth > 31) ? 31 : depth);
          seen |= grown;
          frontier = grown;
        end
        for (int v = 0; v < n; v++) begin
          rep.vertex = CNT_W'(v + 1);
          rep.reach  = seen[v];
          rep.hops   = seen[v] ? hops[v] : '0;
          rep.odd    = ^(edge_rows[v] & in_use);  // self loop is one bit: counts once
          rep.last   = (v + 1 == n);
          reports_due.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: presents queued ops, predicts each one at its transfer, and idles
  // a random number of cycles between transfers. in_valid_i gets at most one
  // assignment per edge so back-to-back ops never glitch low.
  always @(posedge clk_i) begin
    graph_op_t next_op;
    graph_op_t taken;
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        taken.action   = action_i;
        taken.first_v  = first_vertex_i;
        taken.second_v = second_vertex_i;
        apply_op(taken);
        accepted_ops++;
        offer = 1'b0;
      end
      // while stalled nothing is touched: payload holds
      if (!offer) begin
        if (send_pause > 0) begin
          send_pause--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          next_op = pending_ops.pop_front();
          action_i        <= next_op.action;
          first_vertex_i  <= next_op.first_v;
          second_vertex_i <= next_op.second_v;
          in_valid_i      <= 1'b1;
          send_pause = pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transfer against the oldest owed report and
  // stalls at random, or throughout a squeeze window.
  always @(posedge clk_i) begin
    vertex_report_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reports_due.size() == 0) begin
          flag_error($sformatf("unexpected report: vertex=%0d hops=%0d reach=%0d odd=%0d last=%0d",
                               vertex_o, hop_distance_o, reachable_o, odd_degree_o, last_o));
        end else begin
          want = reports_due.pop_front();
          if (vertex_o !== want.vertex || hop_distance_o !== want.hops ||
              reachable_o !== want.reach || odd_degree_o !== want.odd ||
              last_o !== want.last)
            flag_error($sformatf({"report mismatch: expected vertex=%0d hops=%0d reach=%0d ",
                                  "odd=%0d last=%0d, got vertex=%0d hops=%0d reach=%0d ",
                                  "odd=%0d last=%0d"},
                                 want.vertex, want.hops, want.reach, want.odd, want.last,
                                 vertex_o, hop_distance_o, reachable_o, odd_degree_o, last_o));
        end
      end
      if (recv_pause > 0) recv_pause--;
      else recv_pause = pick_pause();
      out_stall_i <= hold_off || (recv_pause > 0);
    end
  end

  // Squeeze: the receiver holds off for a long stretch while the sender keeps
  // offering, so the output backs up and in_stall_o has to rise.
  initial begin
    while (!squeeze_req) @(negedge clk_i);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Wait until every op is in and every report out; an add may still be
  // writing rows after that, so give it time to finish.
  task automatic settle_block();
    while (pending_ops.size() != 0 || in_valid_i || reports_due.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Only called while the block is idle.
  task automatic write_vertex_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vertex_limit = value;
    @(negedge clk_i);
  endtask

  initial begin
    int phase;
    int n_eff;
    int kind;
    int m;
    logic [CNT_W-1:0] count_val;
    foreach (edge_rows[i]) edge_rows[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, count at its reset value of 32.
    queue_op(ACT_QUERY, 1, 0);        // empty graph: only the source is reached
    queue_op(ACT_ADD, 1, 2);
    queue_op(ACT_ADD, 2, 3);
    queue_op(ACT_ADD, 3, 3);          // self loop
    queue_op(ACT_ADD, 32, 31);        // top vertices
    queue_op(ACT_ADD, 0, 5);          // bad vertex: ignored
    queue_op(ACT_ADD, 5, 33);         // bad vertex: ignored
    queue_op(ACT_ADD, 63, 63);        // all field bits set: ignored
    queue_op(ACT_ADD, 10, 0);
    queue_op(ACT_QUERY, 1, 63);
    queue_op(ACT_QUERY, 3, 0);
    queue_op(ACT_QUERY, 32, 17);
    queue_op(ACT_QUERY, 0, 1);        // bad sources reach nothing
    queue_op(ACT_QUERY, 33, 1);
    queue_op(ACT_QUERY, 63, 63);
    queue_op(ACT_SPARE, 63, 63);      // unused action
    queue_op(ACT_SPARE, 0, 0);
    queue_op(ACT_CLEAR, 42, 21);
    queue_op(ACT_QUERY, 2, 0);
    settle_block();

    // Count of one: edge to an inactive vertex is still stored.
    write_vertex_count(6'd1);
    queue_op(ACT_ADD, 1, 20);
    queue_op(ACT_QUERY, 1, 0);
    queue_op(ACT_QUERY, 2, 0);        // above the count
    settle_block();
    write_vertex_count(6'd0);         // acts as 1
    queue_op(ACT_QUERY, 1, 0);
    settle_block();
    write_vertex_count(6'd63);        // acts as 32, stored edge 1-20 now visible
    queue_op(ACT_QUERY, 20, 0);
    settle_block();

    // Random phases, each under its own count.
    phase = 0;
    while (counted_ops < TARGET_OPS) begin
      case (phase)
        0: count_val = 6'd32;
        1: count_val = 6'd2;
        2: count_val = 6'd63;
        3: count_val = 6'd33;
        4: count_val = 6'd1;
        default: begin
          kind = $urandom_range(0, 9);
          if (kind < 7) count_val = CNT_W'($urandom_range(2, 32));
          else if (kind < 8) count_val = CNT_W'($urandom_range(33, 63));
          else count_val = CNT_W'($urandom_range(0, 1));
        end
      endcase
      write_vertex_count(count_val);
      calm = (phase % 4 == 3);
      if (count_val == 0) n_eff = 1;
      else if (count_val > MAX_VERTICES) n_eff = MAX_VERTICES;
      else n_eff = int'(count_val);

      if (phase == 2) queue_chain(MAX_VERTICES, MAX_VERTICES);  // deepest search
      repeat ($urandom_range(2, 4)) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          if ($urandom_range(0, 2) == 0)
            queue_op(ACT_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
          repeat ($urandom_range(1, 10)) queue_op(ACT_ADD, pick_vertex(n_eff), pick_vertex(n_eff));
          queue_op(ACT_QUERY, pick_vertex(n_eff), $urandom_range(0, 63));
        end else if (kind == 6 && n_eff > 1) begin
          m = $urandom_range(2, (n_eff < 8) ? n_eff : 8);
          queue_chain(n_eff, m);
        end else if (kind == 7) begin
          // junk: spare action, adds out of range, sources that reach nothing
          queue_op(ACT_SPARE, $urandom_range(0, 63), $urandom_range(0, 63));
          queue_op(ACT_ADD, $urandom_range(33, 63), $urandom_range(0, 63));
          queue_op(ACT_ADD, $urandom_range(1, 32), 0);
          queue_op(ACT_QUERY, (n_eff < 63) ? $urandom_range(n_eff + 1, 63) : 0,
                   $urandom_range(0, 63));
        end else begin
          repeat ($urandom_range(1, 2))
            queue_op(ACT_QUERY, pick_vertex(n_eff), $urandom_range(0, 63));
        end
      end
      if (phase == 0) begin
        repeat (3) queue_op(ACT_QUERY, $urandom_range(1, n_eff), $urandom_range(0, 63));
        squeeze_req = 1'b1;
      end
      settle_block();
      phase++;
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0 && reports_due.size() == 0) begin
      $display("unit_graph_shortest_path_and_parity_unit_test: done, clean");
    end else begin
      $display("unit_graph_shortest_path_and_parity_unit_test: done, errors");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("unit_graph_shortest_path_and_parity_unit_test: done, errors");
    $finish;
  end

endmodule
